// ===== design/dldr_pkg.sv =====
// Shared types, widths and codes of the dump load duty regulator.
`timescale 1ns / 1ps

package dldr_pkg;

	// Field and register widths
	localparam int VREF_W  = 12;
	localparam int GAIN_W  = 16;
	localparam int MAXD_W  = 16;
	localparam int PER_W   = 16;
	localparam int V_W     = 12;
	localparam int ERR_W   = 13;
	localparam int DUTY_W  = 18;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	// Serial multiplier widths: multiplicand, multiplier, product
	localparam int MA_W    = 17;
	localparam int MB_W    = 16;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int CNT_W   = $clog2(MB_W);

	// Signed gain * error product, and the filter sum
	localparam int P_W     = 29;
	localparam int SUM_W   = 32;

	// Duty limits of the Q2.15 filter state
	localparam logic signed [DUTY_W-1:0] DUTY_MAX = {1'b0, {(DUTY_W-1){1'b1}}};
	localparam logic signed [DUTY_W-1:0] DUTY_MIN = {1'b1, {(DUTY_W-1){1'b0}}};

	// Q15 scaling shift
	localparam int Q_SHIFT = 15;

	// Register indexes of the configuration port
	typedef enum logic [CIDX_W-1:0] {
		REG_VREF   = 2'd0,
		REG_GAIN   = 2'd1,
		REG_MAXD   = 2'd2,
		REG_PERIOD = 2'd3
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_UPD,
		ST_MUL_A,
		ST_MUL_B,
		ST_DONE
	} state_t;

	// Configuration registers as seen by the sequencer
	typedef struct packed {
		logic        [VREF_W-1:0] vref;
		logic signed [GAIN_W-1:0] gain;
		logic        [MAXD_W-1:0] maxd;
		logic        [PER_W-1:0]  period;
	} cfg_t;

	// Request to the serial multiplier
	typedef struct packed {
		logic            start;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

	// Status of the serial multiplier
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic [PER_W-1:0] ca;
		logic [PER_W-1:0] cb;
	} res_t;

endpackage

// ===== design/dump_load_duty_regulator.sv =====
// Top level of the dump load duty regulator: ports, registers, output stage.
//
// One input transaction per regulation tick on the s_ side: s_tdata carries
// the bus voltage sample, s_tuser the halt flag. One result transaction per
// input on the m_ side: compare values for the two dump load PWMs.
// Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata);
// write only while no transaction is in flight.
// All arithmetic runs through one shift-add multiplier that retires one
// multiplier bit per cycle. A halt item takes one product, a positive error
// only the gain product; else the gain product is followed by the first
// load product, and by a second load product when duty spills over. The next
// input is taken in the idle state after the result moves into the output
// register, so the sequencer, not the output, sets the rate.
// The output register holds a result while m_tready is low; the sequencer
// holds the next finished result until that register frees.
// Reset clears the filtered duty, the output valid and loads the register
// defaults: reference 0, gain 0, first load maximum 1.0, period 65535.
`timescale 1ns / 1ps

module dump_load_duty_regulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dldr_pkg::CIDX_W-1:0]    cfg_addr,
	input  logic [dldr_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [11:0] v_hvdc
	input  logic                           s_tuser,   // [0] halt
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata    // [15:0] compare_a, [31:16] compare_b
);

	dldr_pkg::cfg_t              cfg_q;
	dldr_pkg::res_t              res;
	logic                        res_ready;
	logic                        m_tvalid_q;
	logic [dldr_pkg::PER_W-1:0]  ca_q;
	logic [dldr_pkg::PER_W-1:0]  cb_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vref   <= '0;
			cfg_q.gain   <= '0;
			cfg_q.maxd   <= dldr_pkg::MAXD_W'(32768);
			cfg_q.period <= '1;
		end else if (cfg_wr_en) begin
			unique case (dldr_pkg::reg_idx_t'(cfg_addr))
				dldr_pkg::REG_VREF:   cfg_q.vref   <= cfg_wdata[dldr_pkg::VREF_W-1:0];
				dldr_pkg::REG_GAIN:   cfg_q.gain   <= cfg_wdata[dldr_pkg::GAIN_W-1:0];
				dldr_pkg::REG_MAXD:   cfg_q.maxd   <= cfg_wdata[dldr_pkg::MAXD_W-1:0];
				dldr_pkg::REG_PERIOD: cfg_q.period <= cfg_wdata[dldr_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	dldr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_v      (s_tdata[dldr_pkg::V_W-1:0]),
		.in_halt   (s_tuser),
		.in_ready  (s_tready),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: load when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_ready)
			m_tvalid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			ca_q <= res.ca;
			cb_q <= res.cb;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {cb_q, ca_q};

	// An accepted transaction keeps the sequencer busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item in progress");

	// A finished result waits while the output register is blocked
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && m_tvalid && !m_tready |=> res.valid)
		else $error("finished result dropped while output stalled");

	// A drained output with nothing behind it goes empty
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !res.valid |=> !m_tvalid)
		else $error("result repeated on output");

	// The sequencer never takes input while holding a result
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !s_tready)
		else $error("input ready while result pending");

endmodule

// ===== design/dldr_smul.sv =====
// Radix-2 shift-add unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module dldr_smul (
	input  logic                clk,
	input  logic                arst_n,
	input  dldr_pkg::mul_req_t  req,
	output dldr_pkg::mul_rsp_t  rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [dldr_pkg::CNT_W-1:0]        cnt_q;
	logic [dldr_pkg::MA_W-1:0]         a_q;
	logic [dldr_pkg::PROD_W-1:0]       prod_q;
	logic [dldr_pkg::MA_W:0]           sum;

	// Add the multiplicand into the upper half when the current bit is set
	always_comb begin
		sum = {1'b0, prod_q[dldr_pkg::PROD_W-1:dldr_pkg::MB_W]}
			+ (prod_q[0] ? {1'b0, a_q} : '0);
	end

	// Control: count one step per multiplier bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == dldr_pkg::CNT_W'(dldr_pkg::MB_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: load operands, then shift the partial product right
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q    <= req.a;
			prod_q <= {{dldr_pkg::MA_W{1'b0}}, req.b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[dldr_pkg::MB_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

endmodule

// ===== design/dldr_seq.sv =====
// Sequencer and datapath: error, filtered duty update and compare scaling.
`timescale 1ns / 1ps

module dldr_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dldr_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	input  logic [dldr_pkg::V_W-1:0]      in_v,
	input  logic                          in_halt,
	output logic                          in_ready,
	output dldr_pkg::res_t                res,
	input  logic                          res_ready
);

	dldr_pkg::state_t                       state_q, state_d;
	dldr_pkg::mul_req_t                     mreq;
	dldr_pkg::mul_rsp_t                     mrsp;

	logic                                   halt_q;
	logic signed [dldr_pkg::ERR_W-1:0]      err_q;
	logic signed [dldr_pkg::P_W-1:0]        p_q;
	logic signed [dldr_pkg::DUTY_W-1:0]     duty_q;
	logic                                   over_q;
	logic [dldr_pkg::MA_W-1:0]              rem_q;
	logic [dldr_pkg::PER_W-1:0]             ca_q;
	logic [dldr_pkg::PER_W-1:0]             cb_q;

	logic                                   accept;
	logic signed [dldr_pkg::ERR_W-1:0]      err_in;
	logic [dldr_pkg::ERR_W-1:0]             err_neg;
	logic [dldr_pkg::GAIN_W-1:0]            gain_mag;
	logic [dldr_pkg::ERR_W-1:0]             err_mag;
	logic                                   prod_neg;
	logic signed [dldr_pkg::P_W-1:0]        p_mag;
	logic signed [dldr_pkg::SUM_W-1:0]      sum3;
	logic signed [dldr_pkg::SUM_W-1:0]      dfull;
	logic signed [dldr_pkg::DUTY_W-1:0]     dsat;
	logic                                   err_pos;
	logic                                   d_over;
	logic [dldr_pkg::MA_W-1:0]              d_clamp;
	logic [dldr_pkg::DUTY_W-1:0]            scaled;
	logic [dldr_pkg::PER_W-1:0]             scaled_sat;

	dldr_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign accept = in_valid && in_ready;

	// Error and operand magnitudes for the gain product
	always_comb begin
		err_in   = $signed({1'b0, cfg.vref}) - $signed({1'b0, in_v});
		err_neg  = -err_in;
		gain_mag = cfg.gain[dldr_pkg::GAIN_W-1] ? -cfg.gain : cfg.gain;
		err_mag  = err_in[dldr_pkg::ERR_W-1] ? err_neg : err_in;
		prod_neg = cfg.gain[dldr_pkg::GAIN_W-1] ^ err_q[dldr_pkg::ERR_W-1];
		p_mag    = $signed({1'b0, mrsp.prod[dldr_pkg::P_W-2:0]});
	end

	// Filter update: floor((3p + duty) / 4), saturated
	always_comb begin
		sum3  = (dldr_pkg::SUM_W'(p_q) <<< 1) + dldr_pkg::SUM_W'(p_q)
			+ dldr_pkg::SUM_W'(duty_q);
		dfull = sum3 >>> 2;
		priority if (dfull > dldr_pkg::SUM_W'(dldr_pkg::DUTY_MAX))
			dsat = dldr_pkg::DUTY_MAX;
		else if (dfull < dldr_pkg::SUM_W'(dldr_pkg::DUTY_MIN))
			dsat = dldr_pkg::DUTY_MIN;
		else
			dsat = dfull[dldr_pkg::DUTY_W-1:0];
		err_pos = !err_q[dldr_pkg::ERR_W-1] && (err_q != '0);
		d_over  = dsat > $signed({2'b00, cfg.maxd});
		d_clamp = dsat[dldr_pkg::DUTY_W-1] ? '0 : dsat[dldr_pkg::MA_W-1:0];
	end

	// Scale a product back from Q15 and saturate to the period
	always_comb begin
		scaled = mrsp.prod[dldr_pkg::PROD_W-1:dldr_pkg::Q_SHIFT];
		if (scaled > {2'b00, cfg.period})
			scaled_sat = cfg.period;
		else
			scaled_sat = scaled[dldr_pkg::PER_W-1:0];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dldr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state, multiplier requests and handshakes
	always_comb begin
		state_d    = state_q;
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = cfg.period;
		in_ready   = 1'b0;
		res.valid  = 1'b0;
		res.ca     = ca_q;
		res.cb     = cb_q;
		unique case (state_q)
			dldr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mreq.start = 1'b1;
					if (in_halt) begin
						mreq.a  = {1'b0, cfg.maxd};
						state_d = dldr_pkg::ST_MUL_A;
					end else begin
						mreq.a  = {1'b0, gain_mag};
						mreq.b  = {{(dldr_pkg::MB_W - dldr_pkg::ERR_W){1'b0}}, err_mag};
						state_d = dldr_pkg::ST_MUL_P;
					end
				end
			end
			dldr_pkg::ST_MUL_P: begin
				if (mrsp.done)
					state_d = dldr_pkg::ST_UPD;
			end
			dldr_pkg::ST_UPD: begin
				if (err_pos) begin
					state_d = dldr_pkg::ST_DONE;
				end else begin
					mreq.start = 1'b1;
					mreq.a     = d_over ? {1'b0, cfg.maxd} : d_clamp;
					state_d    = dldr_pkg::ST_MUL_A;
				end
			end
			dldr_pkg::ST_MUL_A: begin
				if (mrsp.done) begin
					if (!halt_q && over_q) begin
						mreq.start = 1'b1;
						mreq.a     = rem_q;
						state_d    = dldr_pkg::ST_MUL_B;
					end else begin
						state_d = dldr_pkg::ST_DONE;
					end
				end
			end
			dldr_pkg::ST_MUL_B: begin
				if (mrsp.done)
					state_d = dldr_pkg::ST_DONE;
			end
			dldr_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready)
					state_d = dldr_pkg::ST_IDLE;
			end
			default: state_d = dldr_pkg::ST_IDLE;
		endcase
	end

	// Filter state: update only on a regular tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			duty_q <= '0;
		else if (state_q == dldr_pkg::ST_UPD)
			duty_q <= dsat;
	end

	// Item registers and compare results
	always_ff @(posedge clk) begin
		if (accept) begin
			halt_q <= in_halt;
			err_q  <= err_in;
			over_q <= 1'b0;
		end
		if (state_q == dldr_pkg::ST_MUL_P && mrsp.done)
			p_q <= prod_neg ? -p_mag : p_mag;
		if (state_q == dldr_pkg::ST_UPD) begin
			over_q <= d_over;
			rem_q  <= dldr_pkg::MA_W'(dsat - $signed({2'b00, cfg.maxd}));
			if (err_pos) begin
				ca_q <= '0;
				cb_q <= '0;
			end
		end
		if (state_q == dldr_pkg::ST_MUL_A && mrsp.done) begin
			ca_q <= scaled_sat;
			cb_q <= halt_q ? cfg.period : '0;
		end
		if (state_q == dldr_pkg::ST_MUL_B && mrsp.done)
			cb_q <= scaled_sat;
	end

endmodule
